[src/assert_macros.svh]
// Assertion helpers shared by the RTL files.
// All checks sample on the rising edge of clk and are disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: when cond holds, prop must hold.
`define AST_IMPL(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// Next-cycle implication: when cond holds, prop must hold in the next cycle.
`define AST_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

[src/reb_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// reb_pkg
// Shared types, codes and the quadrature transition table for the rotary
// encoder and push-button event block.
// ----------------------------------------------------------------------------
package reb_pkg;

    // Width of timestamps kept for button timing
    localparam int TIME_WIDTH = 32;
    localparam int IN_TIME_W  = 32;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 2;

    typedef enum logic
    {
        CMD_ENCODER = 1'b0,
        CMD_BUTTON  = 1'b1
    } command_t;

    typedef enum logic [2:0]
    {
        EV_CW      = 3'd0,
        EV_CCW     = 3'd1,
        EV_CW_BTN  = 3'd2,
        EV_CCW_BTN = 3'd3,
        EV_CLICK   = 3'd4,
        EV_LONG    = 3'd5
    } event_code_t;

    typedef enum logic [CFG_IDX_W-1:0]
    {
        REG_BUTTON_PRESENT = 2'd0,
        REG_DEBOUNCE_MS    = 2'd1,
        REG_LONG_CLICK_MS  = 2'd2
    } cfg_reg_t;

    localparam logic [CFG_DATA_W-1:0] DEBOUNCE_RESET   = 16'd50;
    localparam logic [CFG_DATA_W-1:0] LONG_CLICK_RESET = 16'd1000;
    localparam logic [1:0]            PINS_RESET       = 2'b11;

    // One pin-change item as held in the input register
    typedef struct packed
    {
        command_t               command;
        logic                   clk_level;
        logic                   dt_level;
        logic                   btn_level;
        logic [IN_TIME_W-1:0]   time_ms;
    } item_t;

    // Configuration register file contents
    typedef struct packed
    {
        logic                   button_present;
        logic [CFG_DATA_W-1:0]  debounce_ms;
        logic [CFG_DATA_W-1:0]  long_click_ms;
    } cfg_t;

    // Result of one pass through the event logic
    typedef struct packed
    {
        logic        valid;
        event_code_t code;
    } result_t;

    // Quadrature transition table: {prev B, prev A, B, A} -> -1, 0 or +1
    function automatic logic signed [3:0] quad_step(input logic [3:0] idx);
        logic signed [3:0] step;
        case (idx)
            4'd1, 4'd7, 4'd8, 4'd14:  step = 4'sd1;
            4'd2, 4'd4, 4'd11, 4'd13: step = -4'sd1;
            default:                  step = 4'sd0;
        endcase
        return step;
    endfunction

endpackage

[src/reb_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// reb_core
// Decoder state and event logic: quadrature accumulator, button press
// tracking and click timing. Updates state on each fired item.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module reb_core
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             fire,
    input  reb_pkg::item_t   item,
    input  reb_pkg::cfg_t    cfg,
    output reb_pkg::result_t res
);
    import reb_pkg::*;

    logic [1:0]             prev_pins_reg,     prev_pins_next;
    logic signed [3:0]      step_accum_reg,    step_accum_next;
    logic                   btn_pressed_reg,   btn_pressed_next;
    logic [TIME_WIDTH-1:0]  last_btn_time_reg, last_btn_time_next;

    logic [3:0]             idx;
    logic signed [3:0]      sum;
    logic                   held;
    logic [TIME_WIDTH-1:0]  now;
    logic [TIME_WIDTH-1:0]  dur;

    // Hold decoder state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_pins_reg     <= PINS_RESET;
            step_accum_reg    <= '0;
            btn_pressed_reg   <= 1'b0;
            last_btn_time_reg <= '0;
        end
        else
        begin
            prev_pins_reg     <= prev_pins_next;
            step_accum_reg    <= step_accum_next;
            btn_pressed_reg   <= btn_pressed_next;
            last_btn_time_reg <= last_btn_time_next;
        end
    end

    // Shared terms of the encoder and button paths
    always_comb
    begin
        idx  = {prev_pins_reg, item.dt_level, item.clk_level};
        sum  = step_accum_reg + quad_step(idx);
        held = cfg.button_present && !item.btn_level;
        now  = TIME_WIDTH'(item.time_ms);
        dur  = now - last_btn_time_reg;
    end

    // Advance state and form the result for a fired item
    always_comb
    begin
        prev_pins_next     = prev_pins_reg;
        step_accum_next    = step_accum_reg;
        btn_pressed_next   = btn_pressed_reg;
        last_btn_time_next = last_btn_time_reg;
        res.valid          = 1'b0;
        res.code           = EV_CW;

        if (fire)
        begin
            case (item.command)
                CMD_ENCODER:
                begin
                    prev_pins_next   = idx[1:0];
                    step_accum_next  = sum;
                    btn_pressed_next = 1'b0;
                    if (sum < -4'sd3)
                    begin
                        res.valid       = 1'b1;
                        res.code        = held ? EV_CCW_BTN : EV_CCW;
                        step_accum_next = '0;
                    end
                    else if (sum > 4'sd3)
                    begin
                        res.valid       = 1'b1;
                        res.code        = held ? EV_CW_BTN : EV_CW;
                        step_accum_next = '0;
                    end
                end
                CMD_BUTTON:
                begin
                    if (cfg.button_present)
                    begin
                        if (item.btn_level)
                        begin
                            // Release: classify a pending press by its length
                            if (btn_pressed_reg)
                            begin
                                btn_pressed_next = 1'b0;
                                if (dur >= TIME_WIDTH'(cfg.long_click_ms))
                                begin
                                    res.valid = 1'b1;
                                    res.code  = EV_LONG;
                                end
                                else if (dur >= TIME_WIDTH'(cfg.debounce_ms))
                                begin
                                    res.valid = 1'b1;
                                    res.code  = EV_CLICK;
                                end
                            end
                        end
                        else
                        begin
                            btn_pressed_next = 1'b1;
                        end
                        last_btn_time_next = now;
                    end
                end
                default:
                begin
                    res.valid = 1'b0;
                end
            endcase
        end
    end

    `AST_IMPL(a_accum_range, 1'b1, (step_accum_reg >= -4'sd3) && (step_accum_reg <= 4'sd3), "step accumulator left -3..3")
    `AST_NEXT(a_enc_cancels_press, fire && (item.command == CMD_ENCODER), !btn_pressed_reg, "encoder item did not cancel a pending press")
    `AST_IMPL(a_click_needs_release, res.valid && (res.code == EV_CLICK || res.code == EV_LONG), (item.command == CMD_BUTTON) && item.btn_level && btn_pressed_reg, "click without a release of a pending press")

endmodule

[src/rotary_encoder_button_events.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotary_encoder_button_events
// Quadrature decoder with push button: turns pin-change items into step,
// click and long-click events.
// ----------------------------------------------------------------------------
// The block takes one pin-change item per clock cycle while the input does
// not stall: the item is registered, passes once through the decoder state
// update, and any event lands in the output register.
// Throughput is one item per cycle while no stall holds, set by the state update in
// reb_core; an item that causes no event leaves nothing on the output.
// The input stalls only while a result sits unread in the output register
// and the registered item behind it also has to move. Configuration writes
// are always ready and should be made while no item is in flight.
`include "assert_macros.svh"

module rotary_encoder_button_events
(
    input  logic                             clk,
    input  logic                             rst_n,
    // Pin-change items
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic                             command,
    input  logic                             clk_level,
    input  logic                             dt_level,
    input  logic                             btn_level,
    input  logic [reb_pkg::IN_TIME_W-1:0]    time_ms,
    // Events
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [2:0]                       event_code,
    // Configuration writes
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [reb_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [reb_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import reb_pkg::*;

    cfg_t        cfg_reg,        cfg_next;
    logic        s1_valid_reg,   s1_valid_next;
    item_t       s1_item_reg,    s1_item_next;
    logic        out_valid_reg,  out_valid_next;
    event_code_t out_code_reg,   out_code_next;

    logic        out_free;
    logic        s1_fire;
    logic        in_accept;
    result_t     res;

    // Handshake control
    always_comb
    begin
        out_free  = !out_valid_reg || !out_stall;
        s1_fire   = s1_valid_reg && out_free;
        in_stall  = s1_valid_reg && !out_free;
        in_accept = in_valid && !in_stall;
        cfg_ready = 1'b1;
    end

    // Decode configuration writes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_BUTTON_PRESENT: cfg_next.button_present = cfg_data[0];
                REG_DEBOUNCE_MS:    cfg_next.debounce_ms    = cfg_data;
                REG_LONG_CLICK_MS:  cfg_next.long_click_ms  = cfg_data;
                default:            cfg_next                = cfg_reg;
            endcase
        end
    end

    // Load the input register and the output register
    always_comb
    begin
        s1_valid_next  = s1_valid_reg;
        s1_item_next   = s1_item_reg;
        out_valid_next = out_valid_reg;
        out_code_next  = out_code_reg;

        if (in_accept)
        begin
            s1_valid_next          = 1'b1;
            s1_item_next.command   = command_t'(command);
            s1_item_next.clk_level = clk_level;
            s1_item_next.dt_level  = dt_level;
            s1_item_next.btn_level = btn_level;
            s1_item_next.time_ms   = time_ms;
        end
        else if (s1_fire)
        begin
            s1_valid_next = 1'b0;
        end

        if (s1_fire && res.valid)
        begin
            out_valid_next = 1'b1;
            out_code_next  = res.code;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Hold control and configuration state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.button_present <= 1'b1;
            cfg_reg.debounce_ms    <= DEBOUNCE_RESET;
            cfg_reg.long_click_ms  <= LONG_CLICK_RESET;
            s1_valid_reg           <= 1'b0;
            out_valid_reg          <= 1'b0;
        end
        else
        begin
            cfg_reg       <= cfg_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold payload
    always_ff @(posedge clk)
    begin
        s1_item_reg  <= s1_item_next;
        out_code_reg <= out_code_next;
    end

    reb_core u_core
    (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (s1_fire),
        .item  (s1_item_reg),
        .cfg   (cfg_reg),
        .res   (res)
    );

    assign out_valid  = out_valid_reg;
    assign event_code = out_code_reg;

    `AST_IMPL(a_no_overwrite, s1_fire && res.valid, out_free, "result produced while output register blocked")
    `AST_NEXT(a_stall_holds_item, in_stall, s1_valid_reg && $stable(s1_item_reg), "registered item lost during stall")

endmodule
